// ===== hw/rtl/tcpq_pkg.sv =====
// Package for the three-class priority queue.
// Holds the sizing constants, command codes, control structs and address helpers.
// No dependencies.
package tcpq_pkg;

    localparam int CLASS_DEPTH = 16;
    localparam int CLASSES     = 3;
    localparam int CLASS_W     = 2;
    localparam int SLOT_W      = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(CLASS_DEPTH + 1);
    localparam int STORE_DEPTH = CLASSES * CLASS_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);

    localparam int PRIO_W   = 2;
    localparam int ITEMS_W  = 15;
    localparam int ID_W     = 37;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 6;
    localparam int ENTRY_W  = ITEMS_W + ID_W;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_data;
    } tcpq_cmd_t;

    typedef struct packed {
        logic deq_hit;
    } tcpq_stat_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] result;
        if (slot == SLOT_W'(CLASS_DEPTH - 1))
        begin
            result = '0;
        end
        else
        begin
            result = slot + SLOT_W'(1);
        end
        return result;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLASS_W-1:0] cls,
                                                    input logic [SLOT_W-1:0] slot);
        return ADDR_W'(cls) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(slot);
    endfunction

endpackage

// ===== hw/rtl/tcpq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the entry store of the priority queue; no dependencies.
module tcpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/tcpq_ctrl.sv =====
// Controller state machine of the priority queue.
// Sequences capture, execute, store read and result beat; depends on tcpq_pkg.
module tcpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  tcpq_pkg::tcpq_stat_t stat,
    output tcpq_pkg::tcpq_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.load_data = 1'b0;
        in_stall      = 1'b1;
        out_valid     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.deq_hit)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_READ:
            begin
                cmd.load_data = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/tcpq_datapath.sv =====
// Datapath of the priority queue: per-class pointers and counts, entry store, result.
// Depends on tcpq_pkg and tcpq_ram.
module tcpq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcpq_pkg::tcpq_cmd_t                 cmd,
    output tcpq_pkg::tcpq_stat_t                stat,
    input  logic                                kind,
    input  logic [tcpq_pkg::PRIO_W-1:0]         priority_req,
    input  logic [tcpq_pkg::ITEMS_W-1:0]        item_count,
    input  logic [tcpq_pkg::ID_W-1:0]           customer_id,
    output logic [tcpq_pkg::STATUS_W-1:0]       status,
    output logic [tcpq_pkg::PRIO_W-1:0]         out_priority,
    output logic [tcpq_pkg::ITEMS_W-1:0]        out_item_count,
    output logic [tcpq_pkg::ID_W-1:0]           out_customer_id,
    output logic [tcpq_pkg::OCC_W-1:0]          occupancy,
    output logic                                is_empty
);

    logic                              op_kind_reg;
    logic [tcpq_pkg::CLASS_W-1:0]      op_class_reg;
    logic [tcpq_pkg::ITEMS_W-1:0]      op_items_reg;
    logic [tcpq_pkg::ID_W-1:0]         op_id_reg;

    logic [tcpq_pkg::SLOT_W-1:0]       head_reg  [tcpq_pkg::CLASSES];
    logic [tcpq_pkg::SLOT_W-1:0]       head_next [tcpq_pkg::CLASSES];
    logic [tcpq_pkg::SLOT_W-1:0]       tail_reg  [tcpq_pkg::CLASSES];
    logic [tcpq_pkg::SLOT_W-1:0]       tail_next [tcpq_pkg::CLASSES];
    logic [tcpq_pkg::COUNT_W-1:0]      count_reg [tcpq_pkg::CLASSES];
    logic [tcpq_pkg::COUNT_W-1:0]      count_next[tcpq_pkg::CLASSES];

    logic [tcpq_pkg::STATUS_W-1:0]     status_reg;
    logic [tcpq_pkg::PRIO_W-1:0]       out_priority_reg;
    logic [tcpq_pkg::ITEMS_W-1:0]      out_items_reg;
    logic [tcpq_pkg::ID_W-1:0]         out_id_reg;
    logic [tcpq_pkg::OCC_W-1:0]        occupancy_reg;
    logic                              is_empty_reg;

    logic [tcpq_pkg::CLASS_W-1:0]      in_class;
    logic [tcpq_pkg::CLASS_W-1:0]      deq_class;
    logic                              any_held;
    logic                              enq_ok;
    logic                              deq_hit;
    logic [tcpq_pkg::TOTAL_W-1:0]      total_next;

    logic                              wr_en;
    logic [tcpq_pkg::ADDR_W-1:0]       wr_addr;
    logic                              rd_en;
    logic [tcpq_pkg::ADDR_W-1:0]       rd_addr;
    logic [tcpq_pkg::ENTRY_W-1:0]      rd_data;

    // A priority of zero is served as the highest class.
    assign in_class = (priority_req == '0) ? '0 : priority_req - tcpq_pkg::CLASS_W'(1);

    always_comb
    begin
        any_held = (count_reg[0] != '0) || (count_reg[1] != '0) || (count_reg[2] != '0);
        priority if (count_reg[0] != '0)
        begin
            deq_class = tcpq_pkg::CLASS_W'(0);
        end
        else if (count_reg[1] != '0)
        begin
            deq_class = tcpq_pkg::CLASS_W'(1);
        end
        else
        begin
            deq_class = tcpq_pkg::CLASS_W'(2);
        end
    end

    assign enq_ok  = (op_kind_reg == tcpq_pkg::KIND_ENQ)
                     && (count_reg[op_class_reg] != tcpq_pkg::COUNT_W'(tcpq_pkg::CLASS_DEPTH));
    assign deq_hit = (op_kind_reg == tcpq_pkg::KIND_DEQ) && any_held;

    assign stat.deq_hit = deq_hit;

    always_comb
    begin
        for (int i = 0; i < tcpq_pkg::CLASSES; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
            if (cmd.exec && enq_ok && (op_class_reg == tcpq_pkg::CLASS_W'(i)))
            begin
                tail_next[i]  = tcpq_pkg::next_slot(tail_reg[i]);
                count_next[i] = count_reg[i] + tcpq_pkg::COUNT_W'(1);
            end
            if (cmd.exec && deq_hit && (deq_class == tcpq_pkg::CLASS_W'(i)))
            begin
                head_next[i]  = tcpq_pkg::next_slot(head_reg[i]);
                count_next[i] = count_reg[i] - tcpq_pkg::COUNT_W'(1);
            end
        end
        total_next = tcpq_pkg::TOTAL_W'(count_next[0]) + tcpq_pkg::TOTAL_W'(count_next[1])
                     + tcpq_pkg::TOTAL_W'(count_next[2]);
    end

    assign wr_en   = cmd.exec && enq_ok;
    assign wr_addr = tcpq_pkg::slot_addr(op_class_reg, tail_reg[op_class_reg]);
    assign rd_en   = cmd.exec && deq_hit;
    assign rd_addr = tcpq_pkg::slot_addr(deq_class, head_reg[deq_class]);

    tcpq_ram #(
        .WIDTH(tcpq_pkg::ENTRY_W),
        .DEPTH(tcpq_pkg::STORE_DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data({op_items_reg, op_id_reg}),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tcpq_pkg::CLASSES; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < tcpq_pkg::CLASSES; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_kind_reg  <= kind;
            op_class_reg <= in_class;
            op_items_reg <= item_count;
            op_id_reg    <= customer_id;
        end
        if (cmd.exec)
        begin
            if (op_kind_reg == tcpq_pkg::KIND_ENQ)
            begin
                status_reg <= enq_ok ? tcpq_pkg::STATUS_OK : tcpq_pkg::STATUS_FULL;
            end
            else
            begin
                status_reg <= deq_hit ? tcpq_pkg::STATUS_OK : tcpq_pkg::STATUS_EMPTY;
            end
            out_priority_reg <= deq_hit ? tcpq_pkg::PRIO_W'(deq_class) + tcpq_pkg::PRIO_W'(1)
                                        : '0;
            out_items_reg    <= '0;
            out_id_reg       <= '0;
            occupancy_reg    <= tcpq_pkg::OCC_W'(total_next);
            is_empty_reg     <= (total_next == '0);
        end
        if (cmd.load_data)
        begin
            out_items_reg <= rd_data[tcpq_pkg::ENTRY_W-1:tcpq_pkg::ID_W];
            out_id_reg    <= rd_data[tcpq_pkg::ID_W-1:0];
        end
    end

    assign status          = status_reg;
    assign out_priority    = out_priority_reg;
    assign out_item_count  = out_items_reg;
    assign out_customer_id = out_id_reg;
    assign occupancy       = occupancy_reg;
    assign is_empty        = is_empty_reg;

endmodule

// ===== hw/rtl/three_class_priority_queue.sv =====
// Top level of the three-class strict priority queue.
// Joins tcpq_ctrl and tcpq_datapath; depends on tcpq_pkg.
//
//   Channel   Handshake              Fields
//   request   in_valid / in_stall    kind, priority_req, item_count, customer_id
//   result    out_valid / out_stall  status, out_priority, out_item_count,
//                                    out_customer_id, occupancy, is_empty
//
// One request is handled at a time. An enqueue or a dequeue of an empty queue
// passes from acceptance through the execute state to the result beat, and a
// dequeue that returns an entry also passes through a read state for the registered
// read of the entry store. A new request is accepted in the cycle after the result beat
// is taken. Reset clears all class pointers and counts; the store itself is not cleared.
module three_class_priority_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [tcpq_pkg::PRIO_W-1:0]         priority_req,
    input  logic [tcpq_pkg::ITEMS_W-1:0]        item_count,
    input  logic [tcpq_pkg::ID_W-1:0]           customer_id,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tcpq_pkg::STATUS_W-1:0]       status,
    output logic [tcpq_pkg::PRIO_W-1:0]         out_priority,
    output logic [tcpq_pkg::ITEMS_W-1:0]        out_item_count,
    output logic [tcpq_pkg::ID_W-1:0]           out_customer_id,
    output logic [tcpq_pkg::OCC_W-1:0]          occupancy,
    output logic                                is_empty
);

    tcpq_pkg::tcpq_cmd_t  cmd;
    tcpq_pkg::tcpq_stat_t stat;

    tcpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcpq_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (kind),
        .priority_req   (priority_req),
        .item_count     (item_count),
        .customer_id    (customer_id),
        .status         (status),
        .out_priority   (out_priority),
        .out_item_count (out_item_count),
        .out_customer_id(out_customer_id),
        .occupancy      (occupancy),
        .is_empty       (is_empty)
    );

endmodule
